[rtl/core/bmma_pkg.sv]
package bmma_pkg;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 48;
  localparam int IDX_W  = 6;
  localparam int ROWS_CFG_W  = 4;
  localparam int INNER_CFG_W = 7;
  localparam int COLS_CFG_W  = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int OUT_IDX_W   = 3;
  localparam int DIM_CMP_W   = 11;

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT,
    CMD_LOAD_RIGHT,
    CMD_LOAD_ACC,
    CMD_COMPUTE
  } bmma_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS,
    CFG_INNER,
    CFG_COLS,
    CFG_NONE
  } bmma_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_ADD,
    S_EMIT_RD,
    S_EMIT_LOAD
  } bmma_state_t;

  typedef struct packed {
    logic rd_en;
    logic mul_en;
    logic acc_wr;
    logic out_load;
    logic out_last;
  } bmma_ctrl_t;

endpackage

[rtl/core/bmma_mac.sv]
module bmma_mac (
  input  logic                                    clk,
  input  logic                                    mul_en,
  input  logic signed [bmma_pkg::ELEM_W-1:0]      a,
  input  logic signed [bmma_pkg::ELEM_W-1:0]      b,
  input  logic        [bmma_pkg::ACC_W-1:0]       acc_in,
  output logic        [bmma_pkg::ACC_W-1:0]       sum
);

  logic signed [bmma_pkg::PROD_W-1:0] product;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      product <= a * b;
    end
  end

  assign sum = acc_in
             + {{(bmma_pkg::ACC_W - bmma_pkg::PROD_W){product[bmma_pkg::PROD_W-1]}}, product};

endmodule

[rtl/core/bmma_stores.sv]
module bmma_stores #(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 8
) (
  input  logic                                   clk,
  input  logic                                   load_en,
  input  logic [1:0]                             command,
  input  logic [bmma_pkg::IDX_W-1:0]             row_index,
  input  logic [bmma_pkg::IDX_W-1:0]             col_index,
  input  logic [bmma_pkg::ELEM_W-1:0]            element_value,
  input  logic [bmma_pkg::ACC_W-1:0]             accumulator_value,
  input  bmma_pkg::bmma_ctrl_t                   ctrl,
  input  logic [((MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1)-1:0] row_idx,
  input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] inner_idx,
  input  logic [((MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1)-1:0] col_idx,
  input  logic [bmma_pkg::ACC_W-1:0]             acc_sum,
  output logic [bmma_pkg::ELEM_W-1:0]            left_rd,
  output logic [bmma_pkg::ELEM_W-1:0]            right_rd,
  output logic [bmma_pkg::ACC_W-1:0]             acc_rd
);

  localparam int LEFT_DEPTH  = MAX_ROWS * MAX_INNER;
  localparam int RIGHT_DEPTH = MAX_INNER * MAX_COLS;
  localparam int ACC_DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int LAW = (LEFT_DEPTH  > 1) ? $clog2(LEFT_DEPTH)  : 1;
  localparam int RAW = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
  localparam int AAW = (ACC_DEPTH   > 1) ? $clog2(ACC_DEPTH)   : 1;
  localparam logic [bmma_pkg::DIM_CMP_W-1:0] ROWS_L  = bmma_pkg::DIM_CMP_W'(MAX_ROWS);
  localparam logic [bmma_pkg::DIM_CMP_W-1:0] INNER_L = bmma_pkg::DIM_CMP_W'(MAX_INNER);
  localparam logic [bmma_pkg::DIM_CMP_W-1:0] COLS_L  = bmma_pkg::DIM_CMP_W'(MAX_COLS);

  logic [bmma_pkg::ELEM_W-1:0] left_mem  [LEFT_DEPTH];
  logic [bmma_pkg::ELEM_W-1:0] right_mem [RIGHT_DEPTH];
  logic [bmma_pkg::ACC_W-1:0]  acc_mem   [ACC_DEPTH];

  logic [bmma_pkg::DIM_CMP_W-1:0] row_ext;
  logic [bmma_pkg::DIM_CMP_W-1:0] col_ext;
  logic                           left_we;
  logic                           right_we;
  logic                           acc_load_we;
  logic [LAW-1:0]                 left_wa;
  logic [RAW-1:0]                 right_wa;
  logic [AAW-1:0]                 acc_la;
  logic [LAW-1:0]                 left_ra;
  logic [RAW-1:0]                 right_ra;
  logic [AAW-1:0]                 acc_ca;
  logic [AAW-1:0]                 acc_wa;
  logic [bmma_pkg::ACC_W-1:0]     acc_wd;
  logic                           acc_we;

  assign row_ext = bmma_pkg::DIM_CMP_W'(row_index);
  assign col_ext = bmma_pkg::DIM_CMP_W'(col_index);

  assign left_we = load_en && (bmma_pkg::bmma_cmd_t'(command) == bmma_pkg::CMD_LOAD_LEFT)
                && (row_ext < ROWS_L) && (col_ext < INNER_L);
  assign right_we = load_en && (bmma_pkg::bmma_cmd_t'(command) == bmma_pkg::CMD_LOAD_RIGHT)
                 && (row_ext < INNER_L) && (col_ext < COLS_L);
  assign acc_load_we = load_en && (bmma_pkg::bmma_cmd_t'(command) == bmma_pkg::CMD_LOAD_ACC)
                    && (row_ext < ROWS_L) && (col_ext < COLS_L);

  assign left_wa  = LAW'(row_index) * LAW'(MAX_INNER) + LAW'(col_index);
  assign right_wa = RAW'(row_index) * RAW'(MAX_COLS) + RAW'(col_index);
  assign acc_la   = AAW'(row_index) * AAW'(MAX_COLS) + AAW'(col_index);

  assign left_ra  = LAW'(row_idx) * LAW'(MAX_INNER) + LAW'(inner_idx);
  assign right_ra = RAW'(inner_idx) * RAW'(MAX_COLS) + RAW'(col_idx);
  assign acc_ca   = AAW'(row_idx) * AAW'(MAX_COLS) + AAW'(col_idx);

  assign acc_we = ctrl.acc_wr || acc_load_we;
  assign acc_wa = ctrl.acc_wr ? acc_ca : acc_la;
  assign acc_wd = ctrl.acc_wr ? acc_sum : accumulator_value;

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_wa] <= element_value;
    end
    if (ctrl.rd_en) begin
      left_rd <= left_mem[left_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[right_wa] <= element_value;
    end
    if (ctrl.rd_en) begin
      right_rd <= right_mem[right_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    if (ctrl.rd_en) begin
      acc_rd <= acc_mem[acc_ca];
    end
  end

endmodule

[rtl/core/bmma_seq.sv]
module bmma_seq #(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   out_free,
  input  logic [bmma_pkg::ROWS_CFG_W-1:0]        rows_in_use,
  input  logic [bmma_pkg::INNER_CFG_W-1:0]       inner_in_use,
  input  logic [bmma_pkg::COLS_CFG_W-1:0]        cols_in_use,
  output logic                                   idle,
  output bmma_pkg::bmma_ctrl_t                   ctrl,
  output logic [((MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1)-1:0] row_idx,
  output logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] inner_idx,
  output logic [((MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1)-1:0] col_idx
);

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int KCW = $clog2(MAX_INNER + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam logic [bmma_pkg::DIM_CMP_W-1:0] ROWS_L  = bmma_pkg::DIM_CMP_W'(MAX_ROWS);
  localparam logic [bmma_pkg::DIM_CMP_W-1:0] INNER_L = bmma_pkg::DIM_CMP_W'(MAX_INNER);
  localparam logic [bmma_pkg::DIM_CMP_W-1:0] COLS_L  = bmma_pkg::DIM_CMP_W'(MAX_COLS);

  bmma_pkg::bmma_state_t state;
  bmma_pkg::bmma_state_t state_next;

  logic [RCW-1:0] nr;
  logic [KCW-1:0] nk;
  logic [CCW-1:0] nc;
  logic           i_last;
  logic           k_last;
  logic           j_last;

  always_comb begin
    if (rows_in_use == '0) begin
      nr = RCW'(1);
    end else if (bmma_pkg::DIM_CMP_W'(rows_in_use) > ROWS_L) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(rows_in_use);
    end
    if (inner_in_use == '0) begin
      nk = KCW'(1);
    end else if (bmma_pkg::DIM_CMP_W'(inner_in_use) > INNER_L) begin
      nk = KCW'(MAX_INNER);
    end else begin
      nk = KCW'(inner_in_use);
    end
    if (cols_in_use == '0) begin
      nc = CCW'(1);
    end else if (bmma_pkg::DIM_CMP_W'(cols_in_use) > COLS_L) begin
      nc = CCW'(MAX_COLS);
    end else begin
      nc = CCW'(cols_in_use);
    end
  end

  assign i_last = (RCW'(row_idx)   == nr - RCW'(1));
  assign k_last = (KCW'(inner_idx) == nk - KCW'(1));
  assign j_last = (CCW'(col_idx)   == nc - CCW'(1));

  always_comb begin
    state_next = state;
    case (state)
      bmma_pkg::S_IDLE: begin
        if (start) begin
          state_next = bmma_pkg::S_FETCH;
        end
      end
      bmma_pkg::S_FETCH: state_next = bmma_pkg::S_MUL;
      bmma_pkg::S_MUL:   state_next = bmma_pkg::S_ADD;
      bmma_pkg::S_ADD: begin
        if (i_last && k_last && j_last) begin
          state_next = bmma_pkg::S_EMIT_RD;
        end else begin
          state_next = bmma_pkg::S_FETCH;
        end
      end
      bmma_pkg::S_EMIT_RD: state_next = bmma_pkg::S_EMIT_LOAD;
      bmma_pkg::S_EMIT_LOAD: begin
        if (out_free) begin
          state_next = (i_last && j_last) ? bmma_pkg::S_IDLE : bmma_pkg::S_EMIT_RD;
        end
      end
      default: state_next = bmma_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    idle     = 1'b0;
    ctrl     = '0;
    case (state)
      bmma_pkg::S_IDLE:      idle = 1'b1;
      bmma_pkg::S_FETCH:     ctrl.rd_en = 1'b1;
      bmma_pkg::S_MUL:       ctrl.mul_en = 1'b1;
      bmma_pkg::S_ADD:       ctrl.acc_wr = 1'b1;
      bmma_pkg::S_EMIT_RD:   ctrl.rd_en = 1'b1;
      bmma_pkg::S_EMIT_LOAD: begin
        ctrl.out_load = out_free;
        ctrl.out_last = i_last && j_last;
      end
      default: idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bmma_pkg::S_IDLE;
      row_idx   <= '0;
      inner_idx <= '0;
      col_idx   <= '0;
    end else begin
      state <= state_next;
      if (state == bmma_pkg::S_IDLE && start) begin
        row_idx   <= '0;
        inner_idx <= '0;
        col_idx   <= '0;
      end else if (state == bmma_pkg::S_ADD) begin
        if (!j_last) begin
          col_idx <= col_idx + 1'b1;
        end else begin
          col_idx <= '0;
          if (!k_last) begin
            inner_idx <= inner_idx + 1'b1;
          end else begin
            inner_idx <= '0;
            row_idx   <= i_last ? '0 : row_idx + 1'b1;
          end
        end
      end else if (state == bmma_pkg::S_EMIT_LOAD && out_free) begin
        if (!j_last) begin
          col_idx <= col_idx + 1'b1;
        end else begin
          col_idx <= '0;
          row_idx <= i_last ? '0 : row_idx + 1'b1;
        end
      end
    end
  end

  a_write_after_mul: assert property (@(posedge clk) disable iff (rst)
    ctrl.acc_wr |-> $past(ctrl.mul_en))
    else $error("accumulator written without a product");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> out_free)
    else $error("output loaded while occupied");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_load && ctrl.out_last) |=> idle)
    else $error("sequencer busy after final element");

  a_start_only_idle: assert property (@(posedge clk) disable iff (rst)
    (idle && start) |=> ctrl.rd_en)
    else $error("compute did not begin with a fetch");

endmodule

[rtl/core/block_matrix_multiply_accumulate.sv]
// Matrix multiply-accumulate engine for one result block: C += A * B.
// Input channel (in_valid/in_ready) takes one request per handshake:
//   load left, load right or load accumulator write one element in the
//   accepting cycle and produce nothing; a load outside the store is dropped.
//   compute walks all products i, k, j and then emits every C element in
//   row-major order on the output channel, last set on the final one.
// Configuration channel (cfg_valid/cfg_ready) is always ready; write it only
//   while the block is idle. A zero dimension acts as 1, an oversize one as
//   the parameter maximum.
// Loads are accepted back to back while the block is idle. A compute
//   handles its products one at a time: one shared multiplier and adder
//   steps through fetch, multiply and accumulate for each product, and
//   each emitted element needs an accumulator read. in_ready stays low
//   throughout.
// A stalled receiver holds the output register and the sequencer waits in
//   place; nothing is lost or repeated.
// Reset sets the dimension registers to 8, 64 and 8 and returns the
//   sequencer to idle. Store contents are undefined until written.
module block_matrix_multiply_accumulate #(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_INNER = 64,
  parameter int MAX_COLS  = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              command,
  input  logic [bmma_pkg::IDX_W-1:0]              row_index,
  input  logic [bmma_pkg::IDX_W-1:0]              col_index,
  input  logic signed [bmma_pkg::ELEM_W-1:0]      element_value,
  input  logic signed [bmma_pkg::ACC_W-1:0]       accumulator_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [bmma_pkg::OUT_IDX_W-1:0]          out_row,
  output logic [bmma_pkg::OUT_IDX_W-1:0]          out_col,
  output logic signed [bmma_pkg::ACC_W-1:0]       out_value,
  output logic                                    last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [bmma_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bmma_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int RIW = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
  localparam int KIW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int CIW = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;

  logic [bmma_pkg::ROWS_CFG_W-1:0]  rows_in_use;
  logic [bmma_pkg::INNER_CFG_W-1:0] inner_in_use;
  logic [bmma_pkg::COLS_CFG_W-1:0]  cols_in_use;

  bmma_pkg::bmma_ctrl_t             ctrl;
  logic                             idle;
  logic                             accept;
  logic                             start;
  logic                             out_free;
  logic [RIW-1:0]                   row_idx;
  logic [KIW-1:0]                   inner_idx;
  logic [CIW-1:0]                   col_idx;
  logic [bmma_pkg::ELEM_W-1:0]      left_rd;
  logic [bmma_pkg::ELEM_W-1:0]      right_rd;
  logic [bmma_pkg::ACC_W-1:0]       acc_rd;
  logic [bmma_pkg::ACC_W-1:0]       acc_sum;

  assign in_ready  = idle;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign start     = accept && (bmma_pkg::bmma_cmd_t'(command) == bmma_pkg::CMD_COMPUTE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= bmma_pkg::ROWS_CFG_W'(8);
      inner_in_use <= bmma_pkg::INNER_CFG_W'(64);
      cols_in_use  <= bmma_pkg::COLS_CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (bmma_pkg::bmma_cfg_idx_t'(cfg_index))
        bmma_pkg::CFG_ROWS:  rows_in_use  <= cfg_data[bmma_pkg::ROWS_CFG_W-1:0];
        bmma_pkg::CFG_INNER: inner_in_use <= cfg_data[bmma_pkg::INNER_CFG_W-1:0];
        bmma_pkg::CFG_COLS:  cols_in_use  <= cfg_data[bmma_pkg::COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  bmma_seq #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .out_free     (out_free),
    .rows_in_use  (rows_in_use),
    .inner_in_use (inner_in_use),
    .cols_in_use  (cols_in_use),
    .idle         (idle),
    .ctrl         (ctrl),
    .row_idx      (row_idx),
    .inner_idx    (inner_idx),
    .col_idx      (col_idx)
  );

  bmma_stores #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_stores (
    .clk               (clk),
    .load_en           (accept),
    .command           (command),
    .row_index         (row_index),
    .col_index         (col_index),
    .element_value     (element_value),
    .accumulator_value (accumulator_value),
    .ctrl              (ctrl),
    .row_idx           (row_idx),
    .inner_idx         (inner_idx),
    .col_idx           (col_idx),
    .acc_sum           (acc_sum),
    .left_rd           (left_rd),
    .right_rd          (right_rd),
    .acc_rd            (acc_rd)
  );

  bmma_mac u_mac (
    .clk    (clk),
    .mul_en (ctrl.mul_en),
    .a      (left_rd),
    .b      (right_rd),
    .acc_in (acc_rd),
    .sum    (acc_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_row   <= bmma_pkg::OUT_IDX_W'(row_idx);
      out_col   <= bmma_pkg::OUT_IDX_W'(col_idx);
      out_value <= acc_rd;
      last      <= ctrl.out_last;
    end
  end

endmodule

[test/block_matrix_multiply_accumulate_test.sv]
localparam int ROW_LIMIT   = 8;
localparam int INNER_LIMIT = 64;
localparam int COL_LIMIT   = 8;

typedef struct packed {
  logic [2:0]  row;
  logic [2:0]  col;
  logic [47:0] value;
  logic        last;
} result_element_t;

class product_block_tracker;
  logic [3:0] rows_reg;
  logic [6:0] inner_reg;
  logic [3:0] cols_reg;
  logic signed [15:0] left_band [ROW_LIMIT*INNER_LIMIT];
  logic signed [15:0] right_band [INNER_LIMIT*COL_LIMIT];
  logic [47:0] block_sums [ROW_LIMIT*COL_LIMIT];
  bit left_loaded [ROW_LIMIT*INNER_LIMIT];
  bit right_loaded [INNER_LIMIT*COL_LIMIT];
  bit sum_loaded [ROW_LIMIT*COL_LIMIT];
  result_element_t awaited [$];
  int mismatches;
  int requests;
  int effective_requests;
  int computes;
  int elements_seen;

  function new();
    rows_reg = 4'd8;
    inner_reg = 7'd64;
    cols_reg = 4'd8;
    mismatches = 0;
    requests = 0;
    effective_requests = 0;
    computes = 0;
    elements_seen = 0;
  endfunction

  function int clamp(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function int rows_used();
    return clamp(rows_reg, ROW_LIMIT);
  endfunction

  function int inner_used();
    return clamp(inner_reg, INNER_LIMIT);
  endfunction

  function int cols_used();
    return clamp(cols_reg, COL_LIMIT);
  endfunction

  function void note_register(bmma_pkg::bmma_cfg_idx_t idx, logic [6:0] data);
    case (idx)
      bmma_pkg::CFG_ROWS: rows_reg = data[3:0];
      bmma_pkg::CFG_INNER: inner_reg = data;
      bmma_pkg::CFG_COLS: cols_reg = data[3:0];
      default: ;
    endcase
  endfunction

  function void note_request(bmma_pkg::bmma_cmd_t cmd, logic [5:0] r, logic [5:0] c,
                             logic signed [15:0] ev, logic [47:0] av);
    int nr;
    int nk;
    int nc;
    logic signed [47:0] prod;
    result_element_t e;
    requests++;
    case (cmd)
      bmma_pkg::CMD_LOAD_LEFT: begin
        if (r < ROW_LIMIT && c < INNER_LIMIT) begin
          left_band[r*INNER_LIMIT + c] = ev;
          left_loaded[r*INNER_LIMIT + c] = 1'b1;
          effective_requests++;
        end
      end
      bmma_pkg::CMD_LOAD_RIGHT: begin
        if (r < INNER_LIMIT && c < COL_LIMIT) begin
          right_band[r*COL_LIMIT + c] = ev;
          right_loaded[r*COL_LIMIT + c] = 1'b1;
          effective_requests++;
        end
      end
      bmma_pkg::CMD_LOAD_ACC: begin
        if (r < ROW_LIMIT && c < COL_LIMIT) begin
          block_sums[r*COL_LIMIT + c] = av;
          sum_loaded[r*COL_LIMIT + c] = 1'b1;
          effective_requests++;
        end
      end
      default: begin
        nr = rows_used();
        nk = inner_used();
        nc = cols_used();
        computes++;
        effective_requests++;
        for (int i = 0; i < nr; i++)
          for (int k = 0; k < nk; k++)
            for (int j = 0; j < nc; j++) begin
              prod = left_band[i*INNER_LIMIT + k] * right_band[k*COL_LIMIT + j];
              block_sums[i*COL_LIMIT + j] = block_sums[i*COL_LIMIT + j] + prod;
            end
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++) begin
            e.row = 3'(i);
            e.col = 3'(j);
            e.value = block_sums[i*COL_LIMIT + j];
            e.last = (i == nr - 1 && j == nc - 1);
            awaited.insert(awaited.size(), e);
          end
      end
    endcase
  endfunction

  function void check_element(logic [2:0] row, logic [2:0] col, logic [47:0] value,
                              logic last_flag);
    result_element_t e;
    if (awaited.size() == 0) begin
      $error("unexpected result element: row %0d col %0d value %0d", row, col,
             $signed(value));
      mismatches++;
      return;
    end
    e = awaited.pop_front();
    elements_seen++;
    if (row !== e.row) begin
      $error("out_row: expected %0d, actual %0d", e.row, row);
      mismatches++;
    end
    if (col !== e.col) begin
      $error("out_col: expected %0d, actual %0d", e.col, col);
      mismatches++;
    end
    if (value !== e.value) begin
      $error("out_value: expected %0d, actual %0d", $signed(e.value), $signed(value));
      mismatches++;
    end
    if (last_flag !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, last_flag);
      mismatches++;
    end
  endfunction
endclass

module block_matrix_multiply_accumulate_test;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int REQUEST_TARGET = 360;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_TWO_OF_THREE,
    READY_MOSTLY
  } ready_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = bmma_pkg::CMD_LOAD_LEFT;
  logic [bmma_pkg::IDX_W-1:0] row_index = '0;
  logic [bmma_pkg::IDX_W-1:0] col_index = '0;
  logic signed [bmma_pkg::ELEM_W-1:0] element_value = '0;
  logic signed [bmma_pkg::ACC_W-1:0] accumulator_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [bmma_pkg::OUT_IDX_W-1:0] out_row;
  logic [bmma_pkg::OUT_IDX_W-1:0] out_col;
  logic signed [bmma_pkg::ACC_W-1:0] out_value;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bmma_pkg::CFG_IDX_W-1:0] cfg_index = bmma_pkg::CFG_NONE;
  logic [bmma_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  product_block_tracker tracker = new();

  int burst_left = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int mode_left = 0;
  int pattern_step = 0;
  ready_pattern_t ready_pattern = READY_ALWAYS;

  block_matrix_multiply_accumulate #(
    .MAX_ROWS(ROW_LIMIT),
    .MAX_INNER(INNER_LIMIT),
    .MAX_COLS(COL_LIMIT)
  ) uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        tracker.check_element(out_row, out_col, out_value, last);
      pattern_step <= pattern_step + 1;
      if (mode_left == 0) begin
        ready_pattern <= ready_pattern_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(40, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_asked != hold_taken && out_valid) begin
        hold_taken <= hold_asked;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (ready_pattern)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_COIN: out_ready <= 1'($urandom_range(0, 1));
          READY_TWO_OF_THREE: out_ready <= (pattern_step % 3 != 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("block_matrix_multiply_accumulate_test: errors");
    $finish;
  end

  function automatic logic [15:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_sum();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_request(bmma_pkg::bmma_cmd_t cmd, logic [5:0] r, logic [5:0] c,
                              logic [15:0] ev, logic [47:0] av);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    row_index <= r;
    col_index <= c;
    element_value <= ev;
    accumulator_value <= av;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(cmd, r, c, ev, av);
  endtask

  task automatic start_compute();
    send_request(bmma_pkg::CMD_COMPUTE, 6'($urandom), 6'($urandom), pick_element(),
                 pick_sum());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(bmma_pkg::bmma_cfg_idx_t idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_register(idx, data);
  endtask

  task automatic set_dims(logic [6:0] rows_data, logic [6:0] inner_data,
                          logic [6:0] cols_data, bit poke_unused);
    settle();
    write_register(bmma_pkg::CFG_ROWS, rows_data);
    write_register(bmma_pkg::CFG_INNER, inner_data);
    write_register(bmma_pkg::CFG_COLS, cols_data);
    if (poke_unused)
      write_register(bmma_pkg::CFG_NONE, 7'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_unwritten();
    int nr;
    int nk;
    int nc;
    nr = tracker.rows_used();
    nk = tracker.inner_used();
    nc = tracker.cols_used();
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!tracker.left_loaded[i*INNER_LIMIT + k])
          send_request(bmma_pkg::CMD_LOAD_LEFT, 6'(i), 6'(k), pick_element(), pick_sum());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!tracker.right_loaded[k*COL_LIMIT + j])
          send_request(bmma_pkg::CMD_LOAD_RIGHT, 6'(k), 6'(j), pick_element(), pick_sum());
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        if (!tracker.sum_loaded[i*COL_LIMIT + j])
          send_request(bmma_pkg::CMD_LOAD_ACC, 6'(i), 6'(j), pick_element(), pick_sum());
  endtask

  initial begin
    int phase;
    bmma_pkg::bmma_cmd_t cmd;
    logic [5:0] r;
    logic [5:0] c;
    logic [6:0] rd;
    logic [6:0] kd;
    logic [6:0] cd;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrap at both ends of the accumulator, with out-of-range loads that must be dropped
    set_dims(7'd1, 7'd1, 7'd1, 1'b0);
    send_request(bmma_pkg::CMD_LOAD_LEFT, 6'd0, 6'd0, 16'h8000, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_RIGHT, 6'd0, 6'd0, 16'h8000, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_ACC, 6'd0, 6'd0, pick_element(), 48'h7fff_ffff_ffff);
    send_request(bmma_pkg::CMD_LOAD_LEFT, 6'd8, 6'd0, 16'h1234, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_LEFT, 6'd63, 6'd63, 16'h4321, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_RIGHT, 6'd0, 6'd8, 16'h0f0f, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_RIGHT, 6'd63, 6'd63, 16'hf0f0, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_ACC, 6'd8, 6'd0, pick_element(), 48'h1);
    send_request(bmma_pkg::CMD_LOAD_ACC, 6'd0, 6'd63, pick_element(), 48'h2);
    start_compute();
    start_compute();
    send_request(bmma_pkg::CMD_LOAD_LEFT, 6'd0, 6'd0, 16'h7fff, pick_sum());
    send_request(bmma_pkg::CMD_LOAD_ACC, 6'd0, 6'd0, pick_element(), 48'h8000_0000_0000);
    start_compute();

    // zero and oversize register values, plus a write to the unused index
    set_dims(7'd0, 7'd0, 7'h7f, 1'b1);
    fill_unwritten();
    start_compute();

    set_dims(7'h78, 7'd1, 7'h38, 1'b0);
    fill_unwritten();
    hold_asked <= hold_asked + 1;
    start_compute();
    send_request(bmma_pkg::CMD_LOAD_ACC, 6'd7, 6'd7, pick_element(), pick_sum());
    send_request(bmma_pkg::CMD_LOAD_LEFT, 6'd3, 6'd0, pick_element(), pick_sum());
    send_request(bmma_pkg::CMD_LOAD_RIGHT, 6'd0, 6'd5, pick_element(), pick_sum());
    start_compute();

    set_dims(7'd1, 7'd64, 7'd1, 1'b0);
    fill_unwritten();
    start_compute();
    set_dims(7'h71, 7'h7f, 7'h41, 1'b0);
    start_compute();

    phase = 0;
    while (tracker.requests < REQUEST_TARGET) begin
      if (phase % 3 == 0) begin
        if ($urandom_range(0, 4) == 0) begin
          rd = 7'($urandom_range(1, 2));
          kd = 7'($urandom_range(9, 127));
          cd = 7'($urandom_range(1, 2));
        end else begin
          rd = 7'($urandom_range(0, 10));
          kd = 7'($urandom_range(0, 8));
          cd = 7'($urandom_range(0, 10));
        end
        rd[6:4] = 3'($urandom);
        cd[6:4] = 3'($urandom);
        set_dims(rd, kd, cd, $urandom_range(0, 3) == 0);
      end
      repeat ($urandom_range(4, 24)) begin
        cmd = bmma_pkg::bmma_cmd_t'($urandom_range(0, 2));
        r = 6'($urandom);
        c = 6'($urandom);
        if ($urandom_range(0, 9) != 0) begin
          case (cmd)
            bmma_pkg::CMD_LOAD_LEFT: begin
              r = 6'($urandom_range(0, tracker.rows_used() - 1));
              c = 6'($urandom_range(0, tracker.inner_used() - 1));
            end
            bmma_pkg::CMD_LOAD_RIGHT: begin
              r = 6'($urandom_range(0, tracker.inner_used() - 1));
              c = 6'($urandom_range(0, tracker.cols_used() - 1));
            end
            default: begin
              r = 6'($urandom_range(0, tracker.rows_used() - 1));
              c = 6'($urandom_range(0, tracker.cols_used() - 1));
            end
          endcase
        end
        send_request(cmd, r, c, pick_element(), pick_sum());
      end
      fill_unwritten();
      if (phase == 1 || phase == 7)
        hold_asked <= hold_asked + 1;
      start_compute();
      if ($urandom_range(0, 2) == 0)
        start_compute();
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d requests (%0d taking effect), %0d computes, %0d elements checked",
             tracker.requests, tracker.effective_requests, tracker.computes,
             tracker.elements_seen);
    $display("shapes from 1x1x1 up to 8x1x8 and 1x64x1, with zero, oversize and masked sizes");
    if (tracker.mismatches == 0)
      $display("block_matrix_multiply_accumulate_test: clean");
    else
      $display("block_matrix_multiply_accumulate_test: errors");
    $finish;
  end
endmodule

[sim.f]
rtl/core/bmma_pkg.sv
rtl/core/bmma_mac.sv
rtl/core/bmma_stores.sv
rtl/core/bmma_seq.sv
rtl/core/block_matrix_multiply_accumulate.sv
test/block_matrix_multiply_accumulate_test.sv
